[design/hem_pkg.sv]
// ----------------------------------------------------------------------------
// hem_pkg
// Shared types and constants of the histogram equalization map block.
// ----------------------------------------------------------------------------
package hem_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int LEVELS_DEF      = 256;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] category;
        logic signed [31:0] entry_count;
        logic               last_entry;
    } t_cmd;

    typedef struct packed {
        logic [7:0]         mapped_level;
        logic signed [31:0] min_category;
        logic signed [31:0] max_category;
        logic               in_range;
        logic               table_full;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B0,
        S_B1,
        S_B2,
        S_B3,
        S_B4,
        S_SUM_RD,
        S_SUM_AC,
        S_LV_RD,
        S_LV_LD,
        S_LV_DIV,
        S_Q_RD,
        S_Q_CMP
    } t_state;

endpackage

[design/hem_level_div.sv]
// ----------------------------------------------------------------------------
// hem_level_div
// Serial unit for floor(LEVELS * num / den), clamped to LEVELS-1.
// ----------------------------------------------------------------------------
module hem_level_div #(
    parameter int LEVELS = hem_pkg::LEVELS_DEF,
    parameter int SW     = 39
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [SW:0]   i_num,
    input  logic [SW:0]   i_den,
    output logic          o_done,
    output logic [7:0]    o_level
);

    localparam int LW = $clog2(LEVELS + 1);
    localparam int BW = $clog2(LW);
    localparam int RW = SW + 3;
    localparam logic [LW-1:0] LEVELS_V = LW'(LEVELS);
    localparam logic [LW-1:0] LEVEL_MAX = LW'(LEVELS - 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [BW-1:0] r_bit, n_bit;
    logic [RW-1:0] r_rem, n_rem;
    logic [LW-1:0] r_q, n_q;
    logic [SW:0]   r_num, n_num;
    logic [SW:0]   r_den, n_den;
    logic [7:0]    r_level, n_level;

    logic [RW-1:0] rem2, d1, d2;
    logic [LW-1:0] q2;

    // Horner scheme over the bits of LEVELS: the remainder stays below den,
    // so at most two subtractions of den are needed per step.
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_bit   = r_bit;
        n_rem   = r_rem;
        n_q     = r_q;
        n_num   = r_num;
        n_den   = r_den;
        n_level = r_level;
        d1   = RW'(r_den);
        d2   = {d1[RW-2:0], 1'b0};
        rem2 = {r_rem[RW-2:0], 1'b0} + (LEVELS_V[r_bit] ? RW'(r_num) : '0);
        q2   = {r_q[LW-2:0], 1'b0};
        if (i_start) begin
            n_busy = 1'b1;
            n_bit  = BW'(LW - 1);
            n_rem  = '0;
            n_q    = '0;
            n_num  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            if (rem2 >= d2) begin
                n_rem = rem2 - d2;
                n_q   = q2 + LW'(2);
            end else if (rem2 >= d1) begin
                n_rem = rem2 - d1;
                n_q   = q2 + LW'(1);
            end else begin
                n_rem = rem2;
                n_q   = q2;
            end
            if (r_bit == '0) begin
                n_busy  = 1'b0;
                n_done  = 1'b1;
                n_level = (n_q > LEVEL_MAX) ? 8'(LEVEL_MAX) : 8'(n_q);
            end else begin
                n_bit = r_bit - BW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_bit   <= n_bit;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_num   <= n_num;
        r_den   <= n_den;
        r_level <= n_level;
    end

    assign o_done  = r_done;
    assign o_level = r_level;

endmodule

[design/histogram_equalization_map.sv]
// ----------------------------------------------------------------------------
// histogram_equalization_map
// Loads a histogram in ascending category order and answers level queries.
//
// A transaction is taken when i_start is high and o_busy is low; every
// transaction yields exactly one result, shown for one cycle with
// o_result_valid, and the receiver cannot stall it. A load without the last
// flag stores its entry, or drops it when the table is full. A load with the
// last flag builds the map: it finds the ends of the span, totals the counts,
// then gives each entry its level through a serial divider, or level 0 when
// the total is zero. A query walks the stored categories from the low end,
// one entry at a time, because the entry tables sit in memories with a
// registered read. Queries outside the range, or before a map exists, are
// answered straight from the idle state without a walk.
// ----------------------------------------------------------------------------
module histogram_equalization_map #(
    parameter int MAX_ENTRIES = hem_pkg::MAX_ENTRIES_DEF,
    parameter int LEVELS      = hem_pkg::LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hem_pkg::t_cmd     i_cmd,
    output logic              o_busy,
    output logic              o_result_valid,
    output hem_pkg::t_result  o_result
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int NW = AW + 1;
    localparam int SW = 31 + AW;

    // Entry stores; only entries below the loaded count are ever used.
    logic [31:0] mem_cat [0:MAX_ENTRIES-1];
    logic [31:0] mem_cnt [0:MAX_ENTRIES-1];
    logic [7:0]  mem_lvl [0:MAX_ENTRIES-1];

    hem_pkg::t_state r_state, n_state;

    logic [NW-1:0]      r_n, n_n;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_fi, n_fi;
    logic [AW-1:0]      r_la, n_la;
    logic               r_span_empty, n_span_empty;
    logic               r_map_ready, n_map_ready;
    logic               r_dropped, n_dropped;
    logic signed [31:0] r_range_low, n_range_low;
    logic signed [31:0] r_range_high, n_range_high;
    logic signed [31:0] r_qcat, n_qcat;
    logic [SW-1:0]      r_total, n_total;
    logic [SW-1:0]      r_sum, n_sum;
    logic [31:0]        r_c, n_c;
    logic               r_out_valid, n_out_valid;
    hem_pkg::t_result   r_out, n_out;

    // Memory ports.
    logic          we_ent;
    logic [AW-1:0] wa_ent;
    logic          we_lvl;
    logic [7:0]    wd_lvl;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_cat, rd_cnt;
    logic [7:0]    rd_lvl;

    // Divider hookup.
    logic          div_start;
    logic [SW:0]   div_num, div_den;
    logic          div_done;
    logic [7:0]    div_level;

    logic [NW-1:0] n_base;
    logic [31:0]   eff;

    hem_level_div #(
        .LEVELS (LEVELS),
        .SW     (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_level (div_level)
    );

    always_ff @(posedge i_clk) begin
        if (we_ent) begin
            mem_cat[wa_ent] <= i_cmd.category;
            mem_cnt[wa_ent] <= i_cmd.entry_count;
        end
        if (we_lvl) begin
            mem_lvl[r_idx] <= wd_lvl;
        end
        rd_cat <= mem_cat[rd_addr];
        rd_cnt <= mem_cnt[rd_addr];
        rd_lvl <= mem_lvl[rd_addr];
    end

    // A count weighs nothing when it is negative or its category is zero.
    assign eff = (rd_cat != '0 && !rd_cnt[31]) ? rd_cnt : '0;

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_idx        = r_idx;
        n_fi         = r_fi;
        n_la         = r_la;
        n_span_empty = r_span_empty;
        n_map_ready  = r_map_ready;
        n_dropped    = r_dropped;
        n_range_low  = r_range_low;
        n_range_high = r_range_high;
        n_qcat       = r_qcat;
        n_total      = r_total;
        n_sum        = r_sum;
        n_c          = r_c;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        n_out.mapped_level = '0;
        n_out.in_range     = 1'b0;
        we_ent    = 1'b0;
        wa_ent    = '0;
        we_lvl    = 1'b0;
        wd_lvl    = '0;
        rd_addr   = r_idx;
        div_start = 1'b0;
        div_num   = {r_sum, 1'b0} + (SW + 1)'(eff);
        div_den   = {r_total, 1'b0};
        n_base    = r_map_ready ? '0 : r_n;

        case (r_state)
            hem_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_cmd.command == hem_pkg::CMD_LOAD) begin
                        // A load after a finished map opens a new histogram.
                        if (r_map_ready) begin
                            n_map_ready  = 1'b0;
                            n_range_low  = '0;
                            n_range_high = '0;
                            n_dropped    = 1'b0;
                            n_span_empty = 1'b1;
                        end
                        if (n_base < NW'(MAX_ENTRIES)) begin
                            we_ent = 1'b1;
                            wa_ent = n_base[AW-1:0];
                            n_n    = n_base + NW'(1);
                        end else begin
                            n_n       = n_base;
                            n_dropped = 1'b1;
                        end
                        if (i_cmd.last_entry) begin
                            n_state = hem_pkg::S_B0;
                        end else begin
                            n_out_valid = 1'b1;
                        end
                    end else begin
                        n_qcat = i_cmd.category;
                        if (!r_map_ready || i_cmd.category < r_range_low ||
                                i_cmd.category > r_range_high) begin
                            n_out_valid = 1'b1;
                        end else if (r_span_empty) begin
                            n_out_valid    = 1'b1;
                            n_out.in_range = 1'b1;
                        end else begin
                            n_idx   = r_fi;
                            n_state = hem_pkg::S_Q_RD;
                        end
                    end
                end
            end
            hem_pkg::S_B0: begin
                rd_addr = '0;
                n_idx   = '0;
                n_state = hem_pkg::S_B1;
            end
            hem_pkg::S_B1: begin
                if (r_n == NW'(1)) begin
                    // A single entry covers only its own category at level 0.
                    n_range_low  = rd_cat;
                    n_range_high = rd_cat;
                    n_fi         = '0;
                    n_la         = '0;
                    n_idx        = '0;
                    n_span_empty = 1'b0;
                    n_map_ready  = 1'b1;
                    we_lvl       = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = hem_pkg::S_IDLE;
                end else begin
                    n_fi    = (rd_cat == '0) ? AW'(1) : '0;
                    rd_addr = AW'(r_n - NW'(1));
                    n_state = hem_pkg::S_B2;
                end
            end
            hem_pkg::S_B2: begin
                n_la    = (rd_cat == '0) ? AW'(r_n - NW'(2)) : AW'(r_n - NW'(1));
                rd_addr = r_fi;
                n_state = hem_pkg::S_B3;
            end
            hem_pkg::S_B3: begin
                n_range_low = rd_cat;
                rd_addr     = r_la;
                n_state     = hem_pkg::S_B4;
            end
            hem_pkg::S_B4: begin
                n_range_high = rd_cat;
                n_map_ready  = 1'b1;
                n_span_empty = (r_fi > r_la);
                n_total      = '0;
                n_idx        = r_fi;
                if (r_fi > r_la) begin
                    n_out_valid = 1'b1;
                    n_state     = hem_pkg::S_IDLE;
                end else begin
                    n_state = hem_pkg::S_SUM_RD;
                end
            end
            hem_pkg::S_SUM_RD: begin
                n_state = hem_pkg::S_SUM_AC;
            end
            hem_pkg::S_SUM_AC: begin
                n_total = r_total + SW'(eff);
                if (r_idx == r_la) begin
                    n_idx   = r_fi;
                    n_sum   = '0;
                    n_state = hem_pkg::S_LV_RD;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = hem_pkg::S_SUM_RD;
                end
            end
            hem_pkg::S_LV_RD: begin
                n_state = hem_pkg::S_LV_LD;
            end
            hem_pkg::S_LV_LD: begin
                n_c = eff;
                if (r_total == '0) begin
                    we_lvl = 1'b1;
                    n_sum  = r_sum + SW'(eff);
                    if (r_idx == r_la) begin
                        n_out_valid = 1'b1;
                        n_state     = hem_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = hem_pkg::S_LV_RD;
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = hem_pkg::S_LV_DIV;
                end
            end
            hem_pkg::S_LV_DIV: begin
                if (div_done) begin
                    we_lvl = 1'b1;
                    wd_lvl = div_level;
                    n_sum  = r_sum + SW'(r_c);
                    if (r_idx == r_la) begin
                        n_out_valid = 1'b1;
                        n_state     = hem_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = hem_pkg::S_LV_RD;
                    end
                end
            end
            hem_pkg::S_Q_RD: begin
                n_state = hem_pkg::S_Q_CMP;
            end
            hem_pkg::S_Q_CMP: begin
                // The level store is read at the same address as the categories.
                if ($signed(rd_cat) >= r_qcat) begin
                    n_out_valid        = 1'b1;
                    n_out.in_range     = 1'b1;
                    n_out.mapped_level = rd_lvl;
                    n_state            = hem_pkg::S_IDLE;
                end else if (r_idx == r_la) begin
                    n_out_valid    = 1'b1;
                    n_out.in_range = 1'b1;
                    n_state        = hem_pkg::S_IDLE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = hem_pkg::S_Q_RD;
                end
            end
            default: begin
                n_state = hem_pkg::S_IDLE;
            end
        endcase

        n_out.min_category = n_range_low;
        n_out.max_category = n_range_high;
        n_out.table_full   = n_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hem_pkg::S_IDLE;
            r_n          <= '0;
            r_fi         <= '0;
            r_la         <= '0;
            r_span_empty <= 1'b1;
            r_map_ready  <= 1'b0;
            r_dropped    <= 1'b0;
            r_range_low  <= '0;
            r_range_high <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_n          <= n_n;
            r_fi         <= n_fi;
            r_la         <= n_la;
            r_span_empty <= n_span_empty;
            r_map_ready  <= n_map_ready;
            r_dropped    <= n_dropped;
            r_range_low  <= n_range_low;
            r_range_high <= n_range_high;
            r_out_valid  <= n_out_valid;
        end
        r_idx   <= n_idx;
        r_qcat  <= n_qcat;
        r_total <= n_total;
        r_sum   <= n_sum;
        r_c     <= n_c;
        r_out   <= n_out;
    end

    assign o_busy         = (r_state != hem_pkg::S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // A result only follows an accepted transaction or work in progress.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state != hem_pkg::S_IDLE || i_start))
        else $error("result without a transaction");

    // A nonzero level is only ever reported for a category in range.
    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.mapped_level != '0) |-> r_out.in_range)
        else $error("level reported outside the range");

    // Loads are dropped only once the table is full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |-> (r_n == NW'(MAX_ENTRIES)))
        else $error("drop flag set while room remains");

    // The divider is only started while no other division is pending.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_state == hem_pkg::S_LV_LD && r_total != '0))
        else $error("divider started out of turn");

endmodule
